@@ hw/rtl/mlfq_pkg.sv @@
// Shared constants, codes and types of the multilevel feedback queue scheduler.
package mlfq_pkg;

	localparam int MAX_LEVELS  = 4;
	localparam int QUEUE_DEPTH = 64;
	localparam int ID_BITS     = 8;
	localparam int NUM_QUANTA  = 4;

	localparam int LVL_W    = $clog2(MAX_LEVELS);
	localparam int LVLN_W   = LVL_W + 1;
	localparam int PTR_W    = $clog2(QUEUE_DEPTH);
	localparam int CNT_W    = PTR_W + 1;
	localparam int ADDR_W   = LVL_W + PTR_W;
	localparam int QUANT_W  = 16;
	localparam int ACTIVE_W = 3;
	localparam int KIND_W   = 2;
	localparam int STAT_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic [LVL_W-1:0]   lvl_t;
	typedef logic [LVLN_W-1:0]  lvln_t;
	typedef logic [PTR_W-1:0]   ptr_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [ID_BITS-1:0] id_t;
	typedef logic [QUANT_W-1:0] quant_t;
	typedef logic [ACTIVE_W-1:0] active_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD      = 2'd0,
		KIND_DISPATCH = 2'd1,
		KIND_EXPIRE   = 2'd2
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_LEVELS = 3'd0,
		CFG_QUANTUM0      = 3'd1,
		CFG_QUANTUM1      = 3'd2,
		CFG_QUANTUM2      = 3'd3,
		CFG_QUANTUM3      = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} state_t;

	localparam active_t ACTIVE_RESET = active_t'(4);
	localparam quant_t QUANTUM_RESET [NUM_QUANTA] = '{
		quant_t'(2), quant_t'(4), quant_t'(8), quant_t'(16)
	};

endpackage

@@ hw/rtl/mlfq_if.sv @@
// Request and response channel interfaces of the scheduler.
interface mlfq_req_if
	import mlfq_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [ID_BITS-1:0]  process_id;

	modport source (output valid, output kind, output process_id, input ready);
	modport sink   (input valid, input kind, input process_id, output ready);
endinterface

interface mlfq_rsp_if
	import mlfq_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic [ID_BITS-1:0]  granted_id;
	logic [LVL_W-1:0]    level;
	logic [QUANT_W-1:0]  quantum;
	logic                all_empty;

	modport source (output valid, output status, output granted_id, output level,
		output quantum, output all_empty, input ready);
	modport sink   (input valid, input status, input granted_id, input level,
		input quantum, input all_empty, output ready);
endinterface

@@ hw/rtl/mlfq_store_ram.sv @@
// Single-port-write, registered-read memory holding the queued process identifiers.
module mlfq_store_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/multilevel_feedback_queue_scheduler_top.sv @@
// Multilevel feedback queue scheduler: per-level FIFOs in one memory, control and result register.
//
// Usage:
//   req carries one word per event: kind (add, dispatch, expiry) and process_id.
//   rsp returns exactly one word per request: status, granted_id, level, quantum
//   and all_empty, in request order.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// Sequencing:
//   An add or expiry writes the store in its accept cycle; its response is valid
//   in the next cycle. A dispatch reads the head entry from the store, whose read
//   data is registered; a read state then loads it into the response register.
//   No request is accepted in that read state, which follows each dispatch that
//   finds an entry.
// Reset:
//   arst_n clears all queues, the last dispatched level, the response register
//   and restores the level count and quanta. No clearing pass is needed.
// Stall:
//   The response sits in an output register; one further request is accepted
//   only when that register is empty or being drained in the same cycle.
module multilevel_feedback_queue_scheduler_top
	import mlfq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	mlfq_req_if.sink              req,
	mlfq_rsp_if.source            rsp
);

	state_t  state_q, state_d;
	ptr_t    head_q [MAX_LEVELS];
	ptr_t    tail_q [MAX_LEVELS];
	cnt_t    cnt_q  [MAX_LEVELS];
	ptr_t    head_d [MAX_LEVELS];
	ptr_t    tail_d [MAX_LEVELS];
	cnt_t    cnt_d  [MAX_LEVELS];
	lvl_t    last_q, last_d;
	active_t active_q;
	quant_t  quanta_q [NUM_QUANTA];

	logic    rsp_valid_q, rsp_valid_d;
	stat_t   status_q;
	id_t     gid_q;
	lvl_t    level_q;
	quant_t  quantum_q;
	logic    empty_q;

	logic    accept;
	lvln_t   lvl_n, cfg_lvl_n, tgt_n;
	lvl_t    push_lvl, pop_lvl;
	logic    push_req, push_ok, pop_req, found;
	logic    ram_we, ram_re;
	addr_t   ram_waddr, ram_raddr;
	id_t     ram_rdata;
	stat_t   status_d;
	lvl_t    level_d;
	quant_t  quantum_d;
	logic    empty_d;

	function automatic lvln_t level_count(input active_t a);
		lvln_t n;
		if (a == '0) begin
			n = lvln_t'(1);
		end else if (a > active_t'(MAX_LEVELS)) begin
			n = lvln_t'(MAX_LEVELS);
		end else begin
			n = lvln_t'(a);
		end
		return n;
	endfunction

	function automatic ptr_t next_ptr(input ptr_t p);
		return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	assign lvl_n     = level_count(active_q);
	assign cfg_lvl_n = level_count(active_t'(cfg_wdata[ACTIVE_W-1:0]));
	assign accept    = req.valid && req.ready;

	// Expiry target: one below the last dispatched level, saturated at the lowest active one
	always_comb begin
		tgt_n = lvln_t'(last_q) + lvln_t'(1);
		if (tgt_n > lvl_n - lvln_t'(1)) begin
			tgt_n = lvl_n - lvln_t'(1);
		end
	end

	always_comb begin
		found   = 1'b0;
		pop_lvl = '0;
		for (int k = MAX_LEVELS - 1; k >= 0; k--) begin
			if (cnt_q[k] != '0 && lvln_t'(k) < lvl_n) begin
				found   = 1'b1;
				pop_lvl = lvl_t'(k);
			end
		end
	end

	always_comb begin
		push_req = accept && (req.kind == KIND_ADD || req.kind == KIND_EXPIRE);
		pop_req  = accept && (req.kind == KIND_DISPATCH);
		push_lvl = (req.kind == KIND_ADD) ? '0 : tgt_n[LVL_W-1:0];
		push_ok  = cnt_q[push_lvl] < cnt_t'(QUEUE_DEPTH);
	end

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		cnt_d  = cnt_q;
		last_d = last_q;
		if (push_req && push_ok) begin
			tail_d[push_lvl] = next_ptr(tail_q[push_lvl]);
			cnt_d[push_lvl]  = cnt_q[push_lvl] + cnt_t'(1);
		end
		if (pop_req && found) begin
			head_d[pop_lvl] = next_ptr(head_q[pop_lvl]);
			cnt_d[pop_lvl]  = cnt_q[pop_lvl] - cnt_t'(1);
			last_d          = pop_lvl;
		end
		// Drop levels beyond a new level count
		if (cfg_we && cfg_index == CFG_ACTIVE_LEVELS) begin
			for (int k = 0; k < MAX_LEVELS; k++) begin
				if (lvln_t'(k) >= cfg_lvl_n) begin
					head_d[k] = '0;
					tail_d[k] = '0;
					cnt_d[k]  = '0;
				end
			end
		end
	end

	always_comb begin
		ram_we    = push_req && push_ok;
		ram_waddr = {push_lvl, tail_q[push_lvl]};
		ram_re    = pop_req && found;
		ram_raddr = {pop_lvl, head_q[pop_lvl]};
	end

	mlfq_store_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (ID_BITS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req.process_id),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		status_d  = STAT_OK;
		level_d   = '0;
		quantum_d = '0;
		case (req.kind)
			KIND_ADD, KIND_EXPIRE: begin
				level_d  = push_lvl;
				status_d = push_ok ? STAT_OK : STAT_FULL;
			end
			KIND_DISPATCH: begin
				if (found) begin
					level_d   = pop_lvl;
					quantum_d = quanta_q[pop_lvl];
				end else begin
					status_d = STAT_EMPTY;
				end
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
		empty_d = 1'b1;
		for (int k = 0; k < MAX_LEVELS; k++) begin
			if (cnt_d[k] != '0) begin
				empty_d = 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pop_req && found) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready   = 1'b0;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		case (state_q)
			ST_IDLE: begin
				req.ready = !rsp_valid_q || rsp.ready;
				if (accept) begin
					rsp_valid_d = !(pop_req && found);
				end
			end
			ST_READ: begin
				rsp_valid_d = 1'b1;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			last_q      <= '0;
			active_q    <= ACTIVE_RESET;
			quanta_q    <= QUANTUM_RESET;
			for (int k = 0; k < MAX_LEVELS; k++) begin
				head_q[k] <= '0;
				tail_q[k] <= '0;
				cnt_q[k]  <= '0;
			end
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
			last_q      <= last_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			cnt_q       <= cnt_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_ACTIVE_LEVELS: active_q    <= active_t'(cfg_wdata[ACTIVE_W-1:0]);
					CFG_QUANTUM0:      quanta_q[0] <= quant_t'(cfg_wdata);
					CFG_QUANTUM1:      quanta_q[1] <= quant_t'(cfg_wdata);
					CFG_QUANTUM2:      quanta_q[2] <= quant_t'(cfg_wdata);
					CFG_QUANTUM3:      quanta_q[3] <= quant_t'(cfg_wdata);
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_d;
			gid_q     <= '0;
			level_q   <= level_d;
			quantum_q <= quantum_d;
			empty_q   <= empty_d;
		end else if (state_q == ST_READ) begin
			gid_q <= ram_rdata;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.granted_id = gid_q;
	assign rsp.level      = level_q;
	assign rsp.quantum    = quantum_q;
	assign rsp.all_empty  = empty_q;

`ifndef ASSERT_OFF
	a_read_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !req.ready)
		else $error("request accepted during store read");

	a_read_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> rsp_valid_q && state_q == ST_IDLE)
		else $error("dispatch read did not load the response");

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !rsp_valid_q)
		else $error("response register busy during dispatch read");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= cnt_t'(QUEUE_DEPTH) && cnt_q[1] <= cnt_t'(QUEUE_DEPTH) &&
		cnt_q[2] <= cnt_t'(QUEUE_DEPTH) && cnt_q[3] <= cnt_t'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_inactive_empty: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_n <= lvln_t'(3) |-> cnt_q[3] == '0)
		else $error("inactive level holds entries");
`endif

endmodule

@@ tb/mlfq_sched_checker.sv @@
// Scheduler checker: mirrors the per-level queues, predicts each response word and compares it.
module mlfq_sched_checker
	import mlfq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	mlfq_req_if                   req,
	mlfq_rsp_if                   rsp,
	output int                    fail_count,
	output int                    pending,
	output int                    grants,
	output int                    drops,
	output int                    empty_dispatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		stat_t  status;
		id_t    granted;
		lvl_t   level;
		quant_t quantum;
		logic   all_empty;
	} sched_word_t;

	id_t         fifo_mem [MAX_LEVELS][QUEUE_DEPTH];
	ptr_t        rd_ptr [MAX_LEVELS];
	ptr_t        wr_ptr [MAX_LEVELS];
	cnt_t        fill [MAX_LEVELS];
	lvl_t        last_lvl;
	active_t     level_reg;
	quant_t      quantum_reg [NUM_QUANTA];
	sched_word_t expected_q [$];
	int          words_in  = 0;
	int          words_out = 0;

	initial begin
		fail_count       = 0;
		grants           = 0;
		drops            = 0;
		empty_dispatches = 0;
	end

	assign pending = words_in - words_out;

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 40) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string fname, input int word, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("word %0d %s: got %0h, expected %0h", word, fname, got,
				want));
		end
	endtask

	function automatic int levels_in_use();
		if (level_reg == '0) begin
			return 1;
		end
		if (int'(level_reg) > MAX_LEVELS) begin
			return MAX_LEVELS;
		end
		return int'(level_reg);
	endfunction

	function automatic ptr_t next_slot(input ptr_t p);
		return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	function automatic bit queues_empty();
		for (int k = 0; k < MAX_LEVELS; k++) begin
			if (fill[k] != '0) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic bit enqueue(input int lvl, input id_t id);
		if (lvl >= MAX_LEVELS || int'(fill[lvl]) >= QUEUE_DEPTH) begin
			return 1'b0;
		end
		fifo_mem[lvl][wr_ptr[lvl]] = id;
		wr_ptr[lvl] = next_slot(wr_ptr[lvl]);
		fill[lvl]++;
		return 1'b1;
	endfunction

	function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_ACTIVE_LEVELS: begin
				level_reg = data[ACTIVE_W-1:0];
				// drop every level beyond the new count
				for (int k = levels_in_use(); k < MAX_LEVELS; k++) begin
					rd_ptr[k] = '0;
					wr_ptr[k] = '0;
					fill[k]   = '0;
				end
			end
			CFG_QUANTUM0: quantum_reg[0] = data;
			CFG_QUANTUM1: quantum_reg[1] = data;
			CFG_QUANTUM2: quantum_reg[2] = data;
			CFG_QUANTUM3: quantum_reg[3] = data;
			default: ;
		endcase
	endfunction

	function automatic sched_word_t schedule(input logic [KIND_W-1:0] kind, input id_t pid);
		sched_word_t w;
		int          n;
		int          target;
		bit          found;
		w      = '{status: STAT_OK, granted: '0, level: '0, quantum: '0, all_empty: 1'b0};
		n      = levels_in_use();
		found  = 1'b0;
		case (kind)
			KIND_ADD: begin
				if (!enqueue(0, pid)) begin
					w.status = STAT_FULL;
				end
			end
			KIND_DISPATCH: begin
				w.status = STAT_EMPTY;
				for (int k = 0; k < n; k++) begin
					if (!found && fill[k] != '0) begin
						found     = 1'b1;
						w.granted = fifo_mem[k][rd_ptr[k]];
						rd_ptr[k] = next_slot(rd_ptr[k]);
						fill[k]--;
						last_lvl  = lvl_t'(k);
						w.level   = lvl_t'(k);
						w.quantum = quantum_reg[(k < NUM_QUANTA) ? k : NUM_QUANTA - 1];
						w.status  = STAT_OK;
					end
				end
			end
			KIND_EXPIRE: begin
				target = int'(last_lvl) + 1;
				if (target > n - 1) begin
					target = n - 1;
				end
				w.level = lvl_t'(target);
				if (!enqueue(target, pid)) begin
					w.status = STAT_FULL;
				end
			end
			default: ;
		endcase
		w.all_empty = queues_empty();
		if (w.status == STAT_FULL) begin
			drops++;
		end else if (w.status == STAT_EMPTY) begin
			empty_dispatches++;
		end else if (kind == KIND_DISPATCH) begin
			grants++;
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_LEVELS; k++) begin
				rd_ptr[k] = '0;
				wr_ptr[k] = '0;
				fill[k]   = '0;
			end
			last_lvl    = '0;
			level_reg   = ACTIVE_RESET;
			quantum_reg = QUANTUM_RESET;
			expected_q.delete();
			words_in  <= 0;
			words_out <= 0;
		end else begin
			if (cfg_we) begin
				write_register(cfg_index, cfg_wdata);
			end
			// retire the oldest word before queueing a new one
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("word %0d arrived with nothing expected",
						words_out));
				end else begin
					sched_word_t want;
					want = expected_q.pop_front();
					check_field("status", words_out, rsp.status, want.status);
					check_field("granted_id", words_out, rsp.granted_id, want.granted);
					check_field("level", words_out, rsp.level, want.level);
					check_field("quantum", words_out, rsp.quantum, want.quantum);
					check_field("all_empty", words_out, rsp.all_empty, want.all_empty);
				end
				words_out <= words_out + 1;
			end
			if (req.valid && req.ready) begin
				expected_q.push_back(schedule(req.kind, req.process_id));
				words_in <= words_in + 1;
			end
		end
	end

endmodule

@@ tb/testbench.sv @@
// Testbench top: clock, reset, request and configuration stimulus, response back-pressure, verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mlfq_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int RSP_HOLD_CYCLES = 300;
	localparam int STALL_LIMIT     = 4000;
	localparam int PHASE_WORDS     = 210;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  quiet       = 1'b0;
	logic                  rx_hold_req = 1'b0;
	int                    fail_count;
	int                    pending;
	int                    grants;
	int                    drops;
	int                    empty_dispatches;
	int                    words_sent  = 0;
	int                    settings    = 1;
	int                    stall_cycles = 0;

	mlfq_req_if req_ch ();
	mlfq_rsp_if rsp_ch ();

	multilevel_feedback_queue_scheduler_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	mlfq_sched_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.req              (req_ch),
		.rsp              (rsp_ch),
		.fail_count       (fail_count),
		.pending          (pending),
		.grants           (grants),
		.drops            (drops),
		.empty_dispatches (empty_dispatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("multilevel_feedback_queue_scheduler_top test failed");
			$finish;
		end
	end

	// response side: random back-pressure, one long hold-off when asked
	initial begin : response_sink
		bit hold_seen;
		hold_seen    = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
			end else if (!rx_hold_req) begin
				hold_seen = 1'b0;
			end
			rsp_ch.ready <= quiet || ($urandom_range(99) >= 15);
		end
	end

	function automatic id_t rand_id();
		return id_t'($urandom_range(0, (1 << ID_BITS) - 1));
	endfunction

	task automatic send_word(input logic [KIND_W-1:0] kind, input id_t pid);
		while (!quiet && $urandom_range(99) < 15) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.kind       <= kind;
		req_ch.process_id <= pid;
		do @(posedge clk); while (!req_ch.ready);
		if (kind != KIND_UNUSED) begin
			words_sent++;
		end
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic program_regs(input active_t lv, input quant_t q0, input quant_t q1,
		input quant_t q2, input quant_t q3);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		write_reg(CFG_QUANTUM0, q0);
		write_reg(CFG_QUANTUM1, q1);
		write_reg(CFG_QUANTUM2, q2);
		write_reg(CFG_QUANTUM3, q3);
		write_reg(CFG_ACTIVE_LEVELS, {junk[CFG_DATA_W-1:ACTIVE_W], lv});
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic run_directed();
		send_word(KIND_DISPATCH, 8'h00);
		send_word(KIND_UNUSED, 8'hFF);
		send_word(KIND_EXPIRE, 8'h3C);
		send_word(KIND_ADD, 8'h00);
		send_word(KIND_ADD, 8'hFF);
		send_word(KIND_ADD, 8'hA5);
		send_word(KIND_ADD, 8'h5A);
		send_word(KIND_UNUSED, 8'h00);
		send_word(KIND_DISPATCH, 8'h00);
		send_word(KIND_EXPIRE, 8'h00);
		repeat (4) send_word(KIND_DISPATCH, 8'hFF);
		send_word(KIND_EXPIRE, 8'h3C);
		repeat (2) send_word(KIND_DISPATCH, 8'h00);
		send_word(KIND_EXPIRE, 8'h3C);
		send_word(KIND_DISPATCH, 8'h00);
		send_word(KIND_EXPIRE, 8'h3C);
		send_word(KIND_EXPIRE, 8'hC3);
		repeat (3) send_word(KIND_DISPATCH, 8'h00);
	endtask

	task automatic run_burst();
		int pick;
		int len;
		pick = $urandom_range(99);
		if (pick < 22) begin
			len = ($urandom_range(4) == 0) ? $urandom_range(58, 70) : $urandom_range(1, 12);
			repeat (len) send_word(KIND_ADD, rand_id());
		end else if (pick < 42) begin
			len = $urandom_range(1, 20);
			repeat (len) send_word(KIND_DISPATCH, rand_id());
		end else if (pick < 74) begin
			len = $urandom_range(1, 10);
			repeat (len) begin
				send_word(KIND_DISPATCH, rand_id());
				if ($urandom_range(9) < 7) begin
					send_word(KIND_EXPIRE, rand_id());
				end else begin
					send_word(KIND_ADD, rand_id());
				end
			end
		end else if (pick < 88) begin
			len = ($urandom_range(4) == 0) ? $urandom_range(58, 70) : $urandom_range(1, 12);
			send_word(KIND_DISPATCH, rand_id());
			repeat (len) send_word(KIND_EXPIRE, rand_id());
		end else begin
			len = $urandom_range(1, 8);
			repeat (len) send_word(KIND_W'($urandom_range(3)), rand_id());
		end
	endtask

	task automatic run_phase();
		int target;
		target = words_sent + PHASE_WORDS;
		// expire first so a level left over from the previous setting is used
		send_word(KIND_EXPIRE, rand_id());
		while (words_sent < target) begin
			run_burst();
		end
	endtask

	function automatic quant_t rand_quantum();
		return quant_t'($urandom_range(1, 65535));
	endfunction

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_ACTIVE_LEVELS;
		cfg_wdata         = '0;
		req_ch.valid      = 1'b0;
		req_ch.kind       = KIND_ADD;
		req_ch.process_id = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		repeat (QUEUE_DEPTH + 2) send_word(KIND_ADD, rand_id());
		run_phase();

		drain_results();
		program_regs(3'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		run_phase();

		drain_results();
		program_regs(3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_phase();

		drain_results();
		program_regs(3'd7, rand_quantum(), rand_quantum(), rand_quantum(), rand_quantum());
		quiet <= 1'b1;
		run_phase();

		drain_results();
		quiet <= 1'b0;
		program_regs(3'd2, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
		rx_hold_req <= 1'b1;
		run_phase();

		drain_results();
		rx_hold_req <= 1'b0;
		program_regs(3'd3, rand_quantum(), rand_quantum(), rand_quantum(), rand_quantum());
		run_phase();

		drain_results();
		program_regs(3'd4, 16'd1, 16'hFFFF, 16'd1, 16'hFFFF);
		run_phase();

		drain_results();
		repeat (8) @(posedge clk);

		$display("Covered %0d scheduling words over %0d register settings, with a long hold-off",
			words_sent, settings);
		$display("on responses and a stretch without idling: %0d grants, %0d dropped, %0d empty.",
			grants, drops, empty_dispatches);
		if (fail_count == 0) begin
			$display("multilevel_feedback_queue_scheduler_top test passed");
		end else begin
			$display("multilevel_feedback_queue_scheduler_top test failed");
		end
		$finish;
	end

endmodule
